FILE: hdl/qvr_pkg.sv
package qvr_pkg;

   // Field widths
   localparam int V_BITS  = 32;   // Q16.16 coordinate
   localparam int Q_BITS  = 18;   // Q2.16 quaternion component

   // First step: q*v products, summed and rounded to 24 fraction bits
   localparam int PROD1_W   = Q_BITS + V_BITS;        // 50
   localparam int SUM1_W    = PROD1_W + 1;            // 51, three terms
   localparam int MID_SHIFT = 8;
   localparam int MID_W     = SUM1_W - MID_SHIFT;     // 43

   // Second step: t*q split into two partial products
   localparam int SPLIT_W   = 22;                     // unsigned low slice of t
   localparam int HI_W      = MID_W - SPLIT_W;        // 21, signed high slice
   localparam int PH_W      = HI_W + Q_BITS;          // 39
   localparam int PL_W      = SPLIT_W + 1 + Q_BITS;   // 41
   localparam int PROD2_W   = 60;                     // |t*q| < 2^59
   localparam int SUM2_W    = 62;                     // four terms, < 2^61
   localparam int OUT_SHIFT = 24;
   localparam int RES_W     = SUM2_W - OUT_SHIFT;     // 38

   localparam int STAGES    = 6;

   // Register file
   localparam int CSR_AW = 4;
   localparam int CSR_DW = 32;

   typedef enum logic [1:0] {
      QUAT_X = 2'd0,
      QUAT_Y = 2'd1,
      QUAT_Z = 2'd2,
      QUAT_W = 2'd3
   } quat_idx_type;

   localparam logic signed [Q_BITS-1:0] QUAT_X_RESET = 18'sd0;
   localparam logic signed [Q_BITS-1:0] QUAT_Y_RESET = 18'sd0;
   localparam logic signed [Q_BITS-1:0] QUAT_Z_RESET = 18'sd0;
   localparam logic signed [Q_BITS-1:0] QUAT_W_RESET = 18'sd65536;

   localparam logic signed [V_BITS-1:0] SAT_MAX = 32'sh7fff_ffff;
   localparam logic signed [V_BITS-1:0] SAT_MIN = 32'sh8000_0000;

   // t = q*(0,v); rows tx, ty, tz, tw; three terms each
   localparam quat_idx_type MID_QSEL [4][3] = '{
      '{QUAT_W, QUAT_Y, QUAT_Z},
      '{QUAT_W, QUAT_Z, QUAT_X},
      '{QUAT_W, QUAT_X, QUAT_Y},
      '{QUAT_X, QUAT_Y, QUAT_Z}
   };
   localparam logic [1:0] MID_VSEL [4][3] = '{
      '{2'd0, 2'd2, 2'd1},
      '{2'd1, 2'd0, 2'd2},
      '{2'd2, 2'd1, 2'd0},
      '{2'd0, 2'd1, 2'd2}
   };
   localparam bit MID_NEG [4][3] = '{
      '{1'b0, 1'b0, 1'b1},
      '{1'b0, 1'b0, 1'b1},
      '{1'b0, 1'b0, 1'b1},
      '{1'b1, 1'b1, 1'b1}
   };

   // r = t*conj(q); rows x, y, z; four terms each
   localparam quat_idx_type OUT_TSEL [3][4] = '{
      '{QUAT_X, QUAT_W, QUAT_Y, QUAT_Z},
      '{QUAT_Y, QUAT_W, QUAT_Z, QUAT_X},
      '{QUAT_Z, QUAT_W, QUAT_X, QUAT_Y}
   };
   localparam quat_idx_type OUT_QSEL [3][4] = '{
      '{QUAT_W, QUAT_X, QUAT_Z, QUAT_Y},
      '{QUAT_W, QUAT_Y, QUAT_X, QUAT_Z},
      '{QUAT_W, QUAT_Z, QUAT_Y, QUAT_X}
   };
   localparam bit OUT_NEG [3][4] = '{
      '{1'b0, 1'b1, 1'b1, 1'b0},
      '{1'b0, 1'b1, 1'b1, 1'b0},
      '{1'b0, 1'b1, 1'b1, 1'b0}
   };

endpackage

FILE: hdl/qvr_stream_if.sv
interface qvr_req_if
   import qvr_pkg::*;
();
   logic                     valid;
   logic                     ready;
   logic signed [V_BITS-1:0] in_x;
   logic signed [V_BITS-1:0] in_y;
   logic signed [V_BITS-1:0] in_z;

   modport source (output valid, output in_x, output in_y, output in_z, input ready);
   modport sink   (input valid, input in_x, input in_y, input in_z, output ready);
endinterface

interface qvr_rsp_if
   import qvr_pkg::*;
();
   logic                     valid;
   logic                     ready;
   logic signed [V_BITS-1:0] out_x;
   logic signed [V_BITS-1:0] out_y;
   logic signed [V_BITS-1:0] out_z;
   logic                     saturated;

   modport source (output valid, output out_x, output out_y, output out_z,
                   output saturated, input ready);
   modport sink   (input valid, input out_x, input out_y, input out_z,
                   input saturated, output ready);
endinterface

FILE: hdl/quaternion_vector_rotate_top.sv
// A req_ch transfer enters stage 0 and its result moves through each register
// stage in turn, stage 0 to stage 5, before it is valid on rsp_ch.
// One vector per cycle while rsp_ch is ready; six register stages, each with a valid.
// A stalled stage holds; empty stages behind it keep filling (bubbles collapse).
// Reset (synchronous, active high) empties the pipeline and loads the identity
// quaternion (x = y = z = 0, w = 1.0).
module quaternion_vector_rotate_top
   import qvr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,

   qvr_req_if.sink           req_ch,
   qvr_rsp_if.source         rsp_ch,

   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   // ------------------------------------------------------------------
   // Quaternion registers, APB write at the access phase
   // ------------------------------------------------------------------
   logic signed [Q_BITS-1:0] quat_x_ff, quat_y_ff, quat_z_ff, quat_w_ff;
   logic signed [Q_BITS-1:0] quat_rd;
   logic signed [Q_BITS-1:0] q_vec [4];
   logic                     csr_wr;
   quat_idx_type             csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = quat_idx_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         quat_x_ff <= QUAT_X_RESET;
         quat_y_ff <= QUAT_Y_RESET;
         quat_z_ff <= QUAT_Z_RESET;
         quat_w_ff <= QUAT_W_RESET;
      end else if (csr_wr) begin
         unique case (csr_idx)
            QUAT_X: quat_x_ff <= csr_pwdata[Q_BITS-1:0];
            QUAT_Y: quat_y_ff <= csr_pwdata[Q_BITS-1:0];
            QUAT_Z: quat_z_ff <= csr_pwdata[Q_BITS-1:0];
            QUAT_W: quat_w_ff <= csr_pwdata[Q_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         QUAT_X:  quat_rd = quat_x_ff;
         QUAT_Y:  quat_rd = quat_y_ff;
         QUAT_Z:  quat_rd = quat_z_ff;
         QUAT_W:  quat_rd = quat_w_ff;
         default: quat_rd = quat_w_ff;
      endcase
   end

   assign csr_prdata = CSR_DW'(quat_rd);   // sign extended

   // User makes config changes only while idle (not enforced); stages read live regs.
   assign q_vec[QUAT_X] = quat_x_ff;
   assign q_vec[QUAT_Y] = quat_y_ff;
   assign q_vec[QUAT_Z] = quat_z_ff;
   assign q_vec[QUAT_W] = quat_w_ff;

   // ------------------------------------------------------------------
   // Pipeline flow control
   // A stage loads when it is empty or when the stage after it moves.
   // ------------------------------------------------------------------
   logic [STAGES-1:0] vld_ff;
   logic [STAGES-1:0] vld_in;
   logic [STAGES-1:0] en;

   always_comb begin
      en[STAGES-1] = !vld_ff[STAGES-1] || rsp_ch.ready;
      for (int k = STAGES - 2; k >= 0; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
   end

   assign vld_in      = {vld_ff[STAGES-2:0], req_ch.valid};
   assign req_ch.ready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < STAGES; k++) begin
            if (en[k]) begin
               vld_ff[k] <= vld_in[k];
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Stage 0: the twelve q*v products (18 x 32, exact)
   // ------------------------------------------------------------------
   logic signed [V_BITS-1:0]  v_vec [3];
   logic signed [PROD1_W-1:0] p1_in [4][3];
   logic signed [PROD1_W-1:0] p1_ff [4][3];

   assign v_vec[0] = req_ch.in_x;
   assign v_vec[1] = req_ch.in_y;
   assign v_vec[2] = req_ch.in_z;

   for (genvar k = 0; k < 4; k++) begin : g_p1
      for (genvar j = 0; j < 3; j++) begin : g_term
         assign p1_in[k][j] = q_vec[MID_QSEL[k][j]] * v_vec[MID_VSEL[k][j]];
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         p1_ff <= p1_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 1: t = q*(0,v), sum of three, round to 24 fraction bits.
   // Round half up = add half, then arithmetic shift.
   // ------------------------------------------------------------------
   logic signed [SUM1_W-1:0] s1_acc [4];
   logic signed [MID_W-1:0]  t_ff   [4];

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         s1_acc[k] = SUM1_W'(1) <<< (MID_SHIFT - 1);
         for (int j = 0; j < 3; j++) begin
            if (MID_NEG[k][j]) begin
               s1_acc[k] = s1_acc[k] - SUM1_W'(p1_ff[k][j]);
            end else begin
               s1_acc[k] = s1_acc[k] + SUM1_W'(p1_ff[k][j]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         for (int k = 0; k < 4; k++) begin
            t_ff[k] <= s1_acc[k][SUM1_W-1:MID_SHIFT];
         end
      end
   end

   // ------------------------------------------------------------------
   // Stage 2: t*q as two partial products (signed high x q, unsigned low x q)
   // ------------------------------------------------------------------
   logic signed [HI_W-1:0]    t_hi  [3][4];
   logic signed [SPLIT_W:0]   t_lo  [3][4];
   logic signed [PH_W-1:0]    ph_in [3][4];
   logic signed [PL_W-1:0]    pl_in [3][4];
   logic signed [PH_W-1:0]    ph_ff [3][4];
   logic signed [PL_W-1:0]    pl_ff [3][4];

   for (genvar k = 0; k < 3; k++) begin : g_p2
      for (genvar j = 0; j < 4; j++) begin : g_term
         assign t_hi[k][j]  = t_ff[OUT_TSEL[k][j]][MID_W-1:SPLIT_W];
         assign t_lo[k][j]  = {1'b0, t_ff[OUT_TSEL[k][j]][SPLIT_W-1:0]};
         assign ph_in[k][j] = t_hi[k][j] * q_vec[OUT_QSEL[k][j]];
         assign pl_in[k][j] = t_lo[k][j] * q_vec[OUT_QSEL[k][j]];
      end
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         ph_ff <= ph_in;
         pl_ff <= pl_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 3: merge partials into the full t*q products
   // ------------------------------------------------------------------
   logic signed [PROD2_W-1:0] pf_ff [3][4];

   always_ff @(posedge clock) begin
      if (en[3]) begin
         for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 4; j++) begin
               pf_ff[k][j] <= (PROD2_W'(ph_ff[k][j]) <<< SPLIT_W) + PROD2_W'(pl_ff[k][j]);
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Stage 4: sum of four, round to 16 fraction bits
   // ------------------------------------------------------------------
   logic signed [SUM2_W-1:0] s2_acc [3];
   logic signed [RES_W-1:0]  r_ff   [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         s2_acc[k] = SUM2_W'(1) <<< (OUT_SHIFT - 1);
         for (int j = 0; j < 4; j++) begin
            if (OUT_NEG[k][j]) begin
               s2_acc[k] = s2_acc[k] - SUM2_W'(pf_ff[k][j]);
            end else begin
               s2_acc[k] = s2_acc[k] + SUM2_W'(pf_ff[k][j]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         for (int k = 0; k < 3; k++) begin
            r_ff[k] <= s2_acc[k][SUM2_W-1:OUT_SHIFT];
         end
      end
   end

   // ------------------------------------------------------------------
   // Stage 5: saturate to 32 bits, output register
   // In range when the bits above bit 31 all repeat the sign.
   // ------------------------------------------------------------------
   logic signed [V_BITS-1:0] sat_val [3];
   logic [2:0]               clip;
   logic signed [V_BITS-1:0] out_ff  [3];
   logic                     sat_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         clip[k]    = (r_ff[k][RES_W-1:V_BITS-1] != '0) &&
                      (r_ff[k][RES_W-1:V_BITS-1] != '1);
         sat_val[k] = r_ff[k][V_BITS-1:0];
         if (clip[k]) begin
            sat_val[k] = r_ff[k][RES_W-1] ? SAT_MIN : SAT_MAX;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[5]) begin
         out_ff <= sat_val;
         sat_ff <= |clip;
      end
   end

   assign rsp_ch.valid     = vld_ff[STAGES-1];
   assign rsp_ch.out_x     = out_ff[0];
   assign rsp_ch.out_y     = out_ff[1];
   assign rsp_ch.out_z     = out_ff[2];
   assign rsp_ch.saturated = sat_ff;

   // ------------------------------------------------------------------
   // Checks
   // ------------------------------------------------------------------
   // A flagged result carries at least one clipped component.
   a_sat_flag : assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.saturated) |->
         (rsp_ch.out_x == SAT_MAX || rsp_ch.out_x == SAT_MIN ||
          rsp_ch.out_y == SAT_MAX || rsp_ch.out_y == SAT_MIN ||
          rsp_ch.out_z == SAT_MAX || rsp_ch.out_z == SAT_MIN))
      else $error("saturated flag without a clipped component");

   // Input back-pressure only when every stage is full and the output blocked.
   a_full_stall : assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> (vld_ff == '1) && !rsp_ch.ready)
      else $error("input stalled while the pipeline has room");

   // Reset empties the pipe and restores identity rotation.
   a_reset_state : assert property (@(posedge clock)
      reset |=> (vld_ff == '0) && (quat_w_ff == QUAT_W_RESET) &&
                (quat_x_ff == QUAT_X_RESET))
      else $error("bad state after reset");

   // A full first stage that cannot move keeps its item.
   a_hold : assert property (@(posedge clock) disable iff (reset)
      (vld_ff[0] && !en[0]) |=> vld_ff[0])
      else $error("item lost in stalled first stage");

endmodule

FILE: test/tb_quaternion_vector_rotate_top.sv
`timescale 1ns / 1ps

// Quaternion rotation block: every accepted vector gets its expected rotated
// vector computed here, and the rsp_ch transfers are checked in order.
module tb_quaternion_vector_rotate_top;
   import qvr_pkg::*;

   // Fraction bits dropped by the two rounding steps (32 -> 24, 40 -> 16)
   localparam int     MID_DROP    = 8;
   localparam int     OUT_DROP    = 24;
   localparam longint CLIP_HI     = 64'sd2147483647;
   localparam longint CLIP_LO     = -64'sd2147483648;
   localparam int     IDLE_PCT    = 26;
   localparam int     STALL_LIMIT = 4000;   // cycles without any transfer
   localparam int     TAIL_CYCLES = 20;     // pipeline is 6 deep
   localparam int     RAND_PHASES = 8;
   localparam int     PHASE_ITEMS = 200;

   typedef struct packed {
      logic signed [V_BITS-1:0] x;
      logic signed [V_BITS-1:0] y;
      logic signed [V_BITS-1:0] z;
      logic                     sat;
   } rotated_vec_type;

   logic clock = 1'b0;
   logic reset;

   qvr_req_if req_ch ();
   qvr_rsp_if rsp_ch ();

   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [CSR_AW-1:0] csr_paddr;
   logic [CSR_DW-1:0] csr_pwdata;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   // Shadow of the four quaternion registers, indexed by register
   logic signed [Q_BITS-1:0] quat_cfg [4];
   rotated_vec_type          expected_rotations [$];

   bit no_stall;     // both sides run without idling
   int mismatches;
   int vectors_sent;
   int vectors_checked;
   int clipped_seen;
   int quats_loaded;
   int quiet_cycles;

   quaternion_vector_rotate_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------

   // Round to nearest, ties toward +inf: add half an LSB, then floor.
   function automatic longint round_half_up(input longint acc, input int drop);
      return (acc + (64'sd1 <<< (drop - 1))) >>> drop;
   endfunction

   // r = q * (0,v) * conj(q), in two rounded steps, then clipped to Q16.16
   function automatic rotated_vec_type rotate_vector(input logic signed [V_BITS-1:0] vx_in,
                                                     input logic signed [V_BITS-1:0] vy_in,
                                                     input logic signed [V_BITS-1:0] vz_in);
      longint          vx, vy, vz, qx, qy, qz, qw, tx, ty, tz, tw;
      longint          r [3];
      rotated_vec_type res;
      vx = longint'(vx_in);
      vy = longint'(vy_in);
      vz = longint'(vz_in);
      qx = longint'(quat_cfg[QUAT_X]);
      qy = longint'(quat_cfg[QUAT_Y]);
      qz = longint'(quat_cfg[QUAT_Z]);
      qw = longint'(quat_cfg[QUAT_W]);
      // intermediate quaternion, 24 fraction bits
      tx = round_half_up(qw * vx + qy * vz - qz * vy, MID_DROP);
      ty = round_half_up(qw * vy + qz * vx - qx * vz, MID_DROP);
      tz = round_half_up(qw * vz + qx * vy - qy * vx, MID_DROP);
      tw = round_half_up(-(qx * vx) - qy * vy - qz * vz, MID_DROP);
      // vector part of t * conj(q), back to 16 fraction bits
      r[0] = round_half_up(tx * qw - tw * qx - ty * qz + tz * qy, OUT_DROP);
      r[1] = round_half_up(ty * qw - tw * qy - tz * qx + tx * qz, OUT_DROP);
      r[2] = round_half_up(tz * qw - tw * qz - tx * qy + ty * qx, OUT_DROP);
      res.sat = 1'b0;
      for (int i = 0; i < 3; i++) begin
         if (r[i] > CLIP_HI) begin
            r[i]    = CLIP_HI;
            res.sat = 1'b1;
         end else if (r[i] < CLIP_LO) begin
            r[i]    = CLIP_LO;
            res.sat = 1'b1;
         end
      end
      res.x = V_BITS'(r[0]);
      res.y = V_BITS'(r[1]);
      res.z = V_BITS'(r[2]);
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // Result side: random backpressure, in-order compare
   // ---------------------------------------------------------------------

   always @(negedge clock) begin
      rsp_ch.ready = no_stall || ($urandom_range(99) >= IDLE_PCT);
   end

   function automatic void check_field(input string name, input logic [V_BITS-1:0] want,
                                       input logic [V_BITS-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected %0d (0x%h), actual %0d (0x%h)",
                  $time, name, $signed(want), want, $signed(got), got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      rotated_vec_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_rotations.size() == 0) begin
            $display("%0t: result transfer with nothing expected: x=%0d y=%0d z=%0d sat=%0b",
                     $time, rsp_ch.out_x, rsp_ch.out_y, rsp_ch.out_z, rsp_ch.saturated);
            mismatches++;
         end else begin
            want = expected_rotations.pop_front();
            check_field("out_x", want.x, rsp_ch.out_x);
            check_field("out_y", want.y, rsp_ch.out_y);
            check_field("out_z", want.z, rsp_ch.out_z);
            check_field("saturated", V_BITS'(want.sat), V_BITS'(rsp_ch.saturated));
            vectors_checked++;
            if (want.sat)
               clipped_seen++;
         end
      end
   end

   // Watchdog: any transfer or register access restarts the count
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          csr_psel) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                     $time, quiet_cycles, expected_rotations.size());
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Shared tasks; all of them start and end at a falling edge
   // ---------------------------------------------------------------------

   // One transfer on req_ch, with random idle cycles ahead of it unless no_stall
   task automatic send_vector(input logic signed [V_BITS-1:0] x,
                              input logic signed [V_BITS-1:0] y,
                              input logic signed [V_BITS-1:0] z);
      if (!no_stall) begin
         while ($urandom_range(99) < IDLE_PCT) begin
            req_ch.valid = 1'b0;
            @(negedge clock);
         end
      end
      req_ch.valid = 1'b1;
      req_ch.in_x  = x;
      req_ch.in_y  = y;
      req_ch.in_z  = z;
      do @(posedge clock); while (!req_ch.ready);
      expected_rotations.push_back(rotate_vector(x, y, z));
      vectors_sent++;
      @(negedge clock);
   endtask

   // Stop sending and let every expected result come back
   task automatic wait_drained();
      req_ch.valid = 1'b0;
      while (expected_rotations.size() != 0)
         @(negedge clock);
   endtask

   // APB write: setup, then access; the register takes it at the access edge
   task automatic write_quat(input quat_idx_type idx, input logic [CSR_DW-1:0] data);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = CSR_AW'({idx, 2'b00});
      csr_pwdata  = data;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      quat_cfg[idx] = data[Q_BITS-1:0];   // only the low 18 bits are kept
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   // APB read; only the low 18 bits of prdata are compared
   task automatic check_quat_readback(input quat_idx_type idx);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = CSR_AW'({idx, 2'b00});
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata[Q_BITS-1:0] !== quat_cfg[idx]) begin
         $display("%0t: readback of %s mismatch: expected 0x%h, actual 0x%h",
                  $time, idx.name(), quat_cfg[idx], csr_prdata[Q_BITS-1:0]);
         mismatches++;
      end
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
   endtask

   task automatic load_quat(input logic signed [Q_BITS-1:0] qx,
                            input logic signed [Q_BITS-1:0] qy,
                            input logic signed [Q_BITS-1:0] qz,
                            input logic signed [Q_BITS-1:0] qw);
      logic [CSR_DW-1:0] junk;
      // upper data bits are random; the block must drop them
      junk = $urandom;
      write_quat(QUAT_X, {junk[CSR_DW-1:Q_BITS], qx});
      junk = $urandom;
      write_quat(QUAT_Y, {junk[CSR_DW-1:Q_BITS], qy});
      junk = $urandom;
      write_quat(QUAT_Z, {junk[CSR_DW-1:Q_BITS], qz});
      junk = $urandom;
      write_quat(QUAT_W, {junk[CSR_DW-1:Q_BITS], qw});
      quats_loaded++;
   endtask

   function automatic logic signed [V_BITS-1:0] pick_coord();
      int unsigned sel;
      sel = $urandom_range(9);
      if (sel < 4)
         return $urandom;                                   // full range
      if (sel < 8)
         return int'($urandom_range(4194303)) - 2097152;    // within +/-32.0
      case ($urandom_range(4))
         0:       return 32'sh7fff_ffff;
         1:       return 32'sh8000_0000;
         2:       return -32'sd1;
         3:       return 32'sd1;
         default: return 32'sd0;
      endcase
   endfunction

   function automatic logic signed [Q_BITS-1:0] pick_extreme_comp();
      case ($urandom_range(4))
         0:       return 18'sh1ffff;
         1:       return 18'sh20000;
         2:       return 18'sd65536;
         3:       return -18'sd65536;
         default: return 18'sd0;
      endcase
   endfunction

   // Mostly unit quaternions (real rotations); some raw 18-bit and extreme ones
   task automatic load_random_quat();
      real                      comp [4];
      real                      norm;
      logic signed [Q_BITS-1:0] q [4];
      int unsigned              style;
      style = $urandom_range(9);
      norm  = 0.0;
      for (int i = 0; i < 4; i++) begin
         comp[i] = real'($urandom_range(2000)) - 1000.0;
         norm    = norm + comp[i] * comp[i];
      end
      norm = $sqrt(norm);
      for (int i = 0; i < 4; i++) begin
         if (style < 6)
            q[i] = (norm < 1.0) ? 18'sd0 : Q_BITS'($rtoi(comp[i] / norm * 65536.0));
         else if (style < 8)
            q[i] = Q_BITS'($urandom);
         else
            q[i] = pick_extreme_comp();
      end
      if (style < 6 && norm < 1.0)
         q[3] = 18'sd65536;
      load_quat(q[0], q[1], q[2], q[3]);
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Reset leaves the identity quaternion: vectors must come back unchanged
   task automatic test_identity_after_reset();
      check_quat_readback(QUAT_X);
      check_quat_readback(QUAT_Y);
      check_quat_readback(QUAT_Z);
      check_quat_readback(QUAT_W);
      send_vector(32'sd0, 32'sd0, 32'sd0);
      send_vector(32'sd1, -32'sd1, 32'sh7fff_ffff);
      send_vector(32'sh8000_0000, 32'sh7fff_ffff, -32'sd1);
      send_vector(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff);
      send_vector(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
      send_vector(32'sh1234_5678, -32'sh0edc_ba98, 32'sh0001_0000);
      wait_drained();
   endtask

   // Data wider than 18 bits: only the low 18 bits stick
   task automatic test_register_width();
      write_quat(QUAT_X, 32'hfffe_0000);   // -2.0 with all upper bits set
      write_quat(QUAT_Y, 32'habc5_ffff);   // just under +2.0
      write_quat(QUAT_Z, 32'h5555_0000);   // +1.0
      write_quat(QUAT_W, 32'hffff_ffff);   // -1 LSB
      quats_loaded++;
      check_quat_readback(QUAT_X);
      check_quat_readback(QUAT_Y);
      check_quat_readback(QUAT_Z);
      check_quat_readback(QUAT_W);
      send_vector(32'sh0001_0000, 32'sh0002_0000, -32'sh0003_0000);
      send_vector(32'sh7fff_ffff, 32'sh8000_0000, 32'sd1);
      send_vector(32'sd1, 32'sd1, 32'sd1);
      wait_drained();
   endtask

   // Extreme and non-unit quaternions (saturation), a quarter turn, and zero
   task automatic test_quat_extremes();
      load_quat(18'sh20000, 18'sh20000, 18'sh20000, 18'sh20000);
      send_vector(32'sh7fff_ffff, 32'sh8000_0000, 32'sd1);
      send_vector(32'sd1, 32'sd1, 32'sd1);
      wait_drained();
      load_quat(18'sh1ffff, 18'sh1ffff, 18'sh1ffff, 18'sh1ffff);
      send_vector(32'sh8000_0000, 32'sh7fff_ffff, 32'sd0);
      send_vector(32'sh0001_0000, 32'sd0, 32'sd0);
      wait_drained();
      // 90 degrees about z: cos 45 = sin 45 = 0.70711
      load_quat(18'sd0, 18'sd0, 18'sd46341, 18'sd46341);
      send_vector(32'sh0001_0000, 32'sd0, 32'sd0);
      send_vector(32'sd0, 32'sh0001_0000, 32'sd0);
      send_vector(32'sd0, 32'sd0, 32'sh0001_0000);
      wait_drained();
      load_quat(18'sd0, 18'sd0, 18'sd0, 18'sd0);
      send_vector(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
      wait_drained();
   endtask

   // Random quaternion per phase, random vectors; one phase runs with no
   // idling on either side, one pauses halfway until the pipe is empty
   task automatic test_random_rotations();
      for (int phase = 0; phase < RAND_PHASES; phase++) begin
         wait_drained();
         load_random_quat();
         no_stall = (phase == 2);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (phase == 5 && n == PHASE_ITEMS / 2)
               wait_drained();
            send_vector(pick_coord(), pick_coord(), pick_coord());
         end
         no_stall = 1'b0;
      end
      wait_drained();
   endtask

   initial begin
      reset          = 1'b1;
      no_stall       = 1'b0;
      req_ch.valid   = 1'b0;
      req_ch.in_x    = '0;
      req_ch.in_y    = '0;
      req_ch.in_z    = '0;
      rsp_ch.ready   = 1'b0;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = '0;
      quat_cfg[QUAT_X] = 18'sd0;
      quat_cfg[QUAT_Y] = 18'sd0;
      quat_cfg[QUAT_Z] = 18'sd0;
      quat_cfg[QUAT_W] = 18'sd65536;   // identity after reset
      mismatches      = 0;
      vectors_sent    = 0;
      vectors_checked = 0;
      clipped_seen    = 0;
      quats_loaded    = 0;
      quiet_cycles    = 0;
      repeat (9) @(negedge clock);
      reset = 1'b0;

      test_identity_after_reset();
      test_register_width();
      test_quat_extremes();
      test_random_rotations();

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Rotated %0d vectors under %0d quaternion settings; %0d results clipped.",
               vectors_sent, quats_loaded, clipped_seen);
      $display("%0d results compared, %0d mismatches.", vectors_checked, mismatches);
      if (mismatches == 0 && expected_rotations.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
